// File: hdl/cec_pkg.sv
// Package for the C escape collapser: beat types, scan modes, character codes
// and the escape lookup functions. Depends on nothing; every hdl file imports it.
package cec_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
        logic       escapes_found;
    } t_out;

    // One queue entry: the one or two results caused by a single input beat.
    typedef struct packed {
        logic two;
        t_out first;
        t_out second;
    } t_pair;

    // Front to queue.
    typedef struct packed {
        logic  push;
        t_pair pair;
    } t_push;

    // Queue to back.
    typedef struct packed {
        logic  avail;
        t_pair pair;
    } t_head;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_BSLASH = 3'd1,
        MODE_HEX    = 3'd2,
        MODE_OCT    = 3'd3,
        MODE_DONE   = 3'd4
    } t_mode;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] HEX_ALPHA_BIAS = 8'd10;

    // Byte that a simple escape stands for, or zero if the byte is not one.
    function automatic logic [7:0] simple_escape(input logic [7:0] b);
        logic [7:0] s;
        case (b)
            8'h61:     s = 8'd7;   // a
            8'h62:     s = 8'd8;   // b
            8'h66:     s = 8'd12;  // f
            8'h6E:     s = 8'd10;  // n
            8'h72:     s = 8'd13;  // r
            8'h74:     s = 8'd9;   // t
            8'h76:     s = 8'd11;  // v
            CH_BSLASH: s = CH_BSLASH;
            CH_SQUOTE: s = CH_SQUOTE;
            CH_DQUOTE: s = CH_DQUOTE;
            CH_QMARK:  s = CH_QMARK;
            default:   s = CH_NUL;
        endcase
        return s;
    endfunction

    function automatic logic is_dec(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // Bit 4 flags a hex digit, bits 3:0 give its value.
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [7:0] d;
        logic       ok;
        d  = 8'd0;
        ok = 1'b1;
        if (is_dec(b)) begin
            d = b - CH_ZERO;
        end else if ((b >= CH_LOW_A) && (b <= CH_LOW_F)) begin
            d = b - CH_LOW_A + HEX_ALPHA_BIAS;
        end else if ((b >= CH_UP_A) && (b <= CH_UP_F)) begin
            d = b - CH_UP_A + HEX_ALPHA_BIAS;
        end else begin
            ok = 1'b0;
        end
        return {ok, d[3:0]};
    endfunction

endpackage

// File: hdl/c_escape_collapser_core.sv
// C escape collapser, top level. Each result passes through the queue into the output
// register; a second result of the same input follows once the first is taken. Throughput
// is one input beat per cycle while the queue is not full; an input with two results holds
// the single-beat output register for both, so a run of them fills the queue and stalls the
// input. Reset is synchronous, active low: it returns the scan state to normal copy mode and
// empties the queue and the output register. Depends on cec_pkg.
module c_escape_collapser_core import cec_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    // The front scans each accepted beat and writes the one or two results it
    // causes as a single queue entry. Inputs that cause no result (a backslash,
    // a digit that extends a run, anything after a collapsed zero) write nothing.
    // The queue holds two entries, so the input side keeps flowing while the
    // back part sends the second half of a two-result entry or waits on i_stall.
    logic  full;
    logic  accept;
    logic  pop;
    t_push push;
    t_head head;

    assign accept  = i_valid && !full;
    assign o_stall = full;

    cec_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_data),
        .o_push   (push)
    );

    cec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full)
    );

    // The back part owns the output register; its valid comes from a flop and
    // never looks at i_stall.
    cec_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

// File: hdl/cec_front.sv
// Front part of the escape collapser: scan state machine that classifies each
// input beat and forms the one or two results it causes. Uses cec_pkg.
module cec_front import cec_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_in   i_data,
    output t_push o_push
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_acc, n_acc;
    logic       r_any, n_any;

    logic [2:0] emit_v;
    logic [7:0] emit_b [3];
    logic [1:0] k;
    t_out       s0, s1;
    logic [4:0] hv;
    logic [7:0] esc;
    logic [7:0] b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_acc  <= 8'd0;
            r_any  <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_any  <= n_any;
        end
    end

    always_comb begin
        b      = i_data.in_byte;
        hv     = hex_val(b);
        esc    = simple_escape(b);
        n_mode = r_mode;
        n_acc  = r_acc;
        n_any  = r_any;
        emit_v = 3'b000;
        for (int i = 0; i < 3; i++) begin
            emit_b[i] = 8'd0;
        end

        case (r_mode)
            MODE_DONE: begin
                n_mode = MODE_DONE;
            end
            MODE_BSLASH: begin
                if (esc != CH_NUL) begin
                    n_any     = 1'b1;
                    emit_v[0] = 1'b1;
                    emit_b[0] = esc;
                    n_mode    = MODE_NORMAL;
                end else if ((b == CH_LOW_X) || (b == CH_UP_X)) begin
                    n_any  = 1'b1;
                    n_acc  = 8'd0;
                    n_mode = MODE_HEX;
                end else if (is_dec(b)) begin
                    n_any  = 1'b1;
                    n_acc  = b - CH_ZERO;
                    n_mode = MODE_OCT;
                end else begin
                    // Unknown escape: the backslash and the byte pass unchanged; a NUL ends the output.
                    emit_v[0] = 1'b1;
                    emit_b[0] = CH_BSLASH;
                    if (b == CH_NUL) begin
                        n_mode = MODE_DONE;
                    end else begin
                        emit_v[1] = 1'b1;
                        emit_b[1] = b;
                        n_mode    = MODE_NORMAL;
                    end
                end
            end
            MODE_HEX, MODE_OCT: begin
                if ((r_mode == MODE_HEX) && hv[4]) begin
                    n_acc = {r_acc[3:0], hv[3:0]};
                end else if ((r_mode == MODE_OCT) && is_dec(b)) begin
                    n_acc = {r_acc[4:0], 3'b000} + (b - CH_ZERO);
                end else if (r_acc == 8'd0) begin
                    // A run that collapses to zero ends the output.
                    n_mode = MODE_DONE;
                end else begin
                    emit_v[0] = 1'b1;
                    emit_b[0] = r_acc;
                    if (b == CH_BSLASH) begin
                        n_mode = MODE_BSLASH;
                    end else if (b == CH_NUL) begin
                        n_mode = MODE_DONE;
                    end else begin
                        emit_v[1] = 1'b1;
                        emit_b[1] = b;
                        n_mode    = MODE_NORMAL;
                    end
                end
            end
            default: begin
                if (b == CH_BSLASH) begin
                    n_mode = MODE_BSLASH;
                end else if (b == CH_NUL) begin
                    n_mode = MODE_DONE;
                end else begin
                    emit_v[0] = 1'b1;
                    emit_b[0] = b;
                    n_mode    = MODE_NORMAL;
                end
            end
        endcase

        // End of string: close a pending run or a lone backslash.
        if (i_data.in_last) begin
            if (((n_mode == MODE_HEX) || (n_mode == MODE_OCT)) && (n_acc != 8'd0)) begin
                emit_v[2] = 1'b1;
                emit_b[2] = n_acc;
            end else if (n_mode == MODE_BSLASH) begin
                emit_v[2] = 1'b1;
                emit_b[2] = CH_BSLASH;
            end
        end

        // Pack the emitted bytes into the first free slots.
        s0 = '0;
        s1 = '0;
        k  = 2'd0;
        for (int i = 0; i < 3; i++) begin
            if (emit_v[i]) begin
                if (k == 2'd0) begin
                    s0.out_byte  = emit_b[i];
                    s0.out_valid = 1'b1;
                end else begin
                    s1.out_byte  = emit_b[i];
                    s1.out_valid = 1'b1;
                end
                k = k + 2'd1;
            end
        end

        if (i_data.in_last) begin
            if (k == 2'd0) begin
                s0.out_last      = 1'b1;
                s0.escapes_found = n_any;
                k                = 2'd1;
            end else if (k == 2'd1) begin
                s0.out_last      = 1'b1;
                s0.escapes_found = n_any;
            end else begin
                s1.out_last      = 1'b1;
                s1.escapes_found = n_any;
            end
            n_mode = MODE_NORMAL;
            n_acc  = 8'd0;
            n_any  = 1'b0;
        end

        o_push.push        = i_accept && (k != 2'd0);
        o_push.pair.two    = (k == 2'd2);
        o_push.pair.first  = s0;
        o_push.pair.second = s1;
    end

endmodule

// File: hdl/cec_queue.sv
// Short queue of result pairs between the front and back parts of the
// escape collapser. Uses cec_pkg for the entry type and depth.
module cec_queue import cec_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output t_head o_head,
    output logic  o_full
);

    t_pair               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QPTR_W:0]     r_cnt;
    logic                pop_ok;

    assign pop_ok = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push.push, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_head.avail = (r_cnt != '0);
    assign o_head.pair  = r_mem[r_rd];
    assign o_full       = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));

endmodule

// File: hdl/cec_back.sv
// Back part of the escape collapser: drains queue entries into the output
// register, one result beat per cycle while i_stall is low. Uses cec_pkg.
module cec_back import cec_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_head i_head,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_stall,
    output t_out  o_data
);

    logic r_valid;
    t_out r_out;
    logic r_has2;
    t_out r_second;
    logic free;

    assign free  = !r_valid || !i_stall;
    assign o_pop = free && !r_has2 && i_head.avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_has2  <= 1'b0;
        end else if (free) begin
            if (r_has2) begin
                r_valid <= 1'b1;
                r_has2  <= 1'b0;
            end else if (i_head.avail) begin
                r_valid <= 1'b1;
                r_has2  <= i_head.pair.two;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free) begin
            if (r_has2) begin
                r_out <= r_second;
            end else if (i_head.avail) begin
                r_out    <= i_head.pair.first;
                r_second <= i_head.pair.second;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

endmodule
